FILE: hdl/dvlps_pkg.sv
// Shared types, codes and helper functions of the DSI video line packet sequencer.
`timescale 1ns / 1ps

package dvlps_pkg;

	// DSI data type codes of the short sync packets.
	localparam logic [5:0] DT_VSS = 6'h01;
	localparam logic [5:0] DT_VSE = 6'h11;
	localparam logic [5:0] DT_HSS = 6'h21;
	localparam logic [5:0] DT_HSE = 6'h31;

	// DSI data type codes of the long pixel packets, one for each pixel format.
	localparam logic [5:0] DT_RGB565  = 6'h0E;
	localparam logic [5:0] DT_RGB666P = 6'h1E;
	localparam logic [5:0] DT_RGB666L = 6'h2E;
	localparam logic [5:0] DT_RGB888  = 6'h3E;

	// Pixel format codes.
	localparam logic [1:0] FMT_RGB565  = 2'd0;
	localparam logic [1:0] FMT_RGB666P = 2'd1;
	localparam logic [1:0] FMT_RGB666L = 2'd2;
	localparam logic [1:0] FMT_RGB888  = 2'd3;

	// Payload CRC16: reflected polynomial, all-ones start value, no final inversion.
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE  = 4'd0,
		CFG_VSYNC   = 4'd1,
		CFG_VBACK   = 4'd2,
		CFG_VACTIVE = 4'd3,
		CFG_VFRONT  = 4'd4,
		CFG_HACTIVE = 4'd5,
		CFG_CHANNEL = 4'd6,
		CFG_FORMAT  = 4'd7
	} cfg_reg_t;

	// One packet request from the sequencer to the output register.
	typedef struct packed {
		logic [5:0]  dtype;
		logic [1:0]  chan;
		logic [13:0] wcount;
		logic [15:0] crc;
		logic        has_crc;
		logic        frame_start;
		logic        last;
	} pkt_t;

	// Advance the CRC by one payload byte, least significant bit first.
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// Data type of the pixel packet for a pixel format.
	function automatic logic [5:0] pix_type(input logic [1:0] fmt);
		logic [5:0] dt;
		case (fmt)
			FMT_RGB565:  dt = DT_RGB565;
			FMT_RGB666P: dt = DT_RGB666P;
			FMT_RGB666L: dt = DT_RGB666L;
			FMT_RGB888:  dt = DT_RGB888;
			default:     dt = DT_RGB888;
		endcase
		return dt;
	endfunction

endpackage

FILE: hdl/dvlps_crc_ser.sv
// Byte-serial CRC engine over the test-pattern payload of one active line.
`timescale 1ns / 1ps

module dvlps_crc_ser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [11:0] pix_cnt,
	input  logic [7:0]  line_off,
	output logic        done,
	output logic [15:0] crc
);

	logic        busy_q;
	logic        done_q;
	logic [11:0] x_q;
	logic [11:0] cnt_q;
	logic [7:0]  off_q;
	logic [1:0]  byte_q;
	logic [23:0] sh_q;
	logic [15:0] crc_q;
	logic [11:0] x_nxt;

	assign x_nxt = x_q + 12'd1;

	// Control: run three bytes per pixel until the pixel count is reached.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			byte_q <= 2'd0;
			x_q    <= 12'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			byte_q <= 2'd0;
			x_q    <= 12'd0;
		end else if (busy_q) begin
			if (byte_q == 2'd2) begin
				byte_q <= 2'd0;
				if (x_nxt == cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					x_q <= x_nxt;
				end
			end else begin
				byte_q <= byte_q + 2'd1;
			end
		end
	end

	// Datapath: the pixel bytes shift out one byte a cycle into the CRC.
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= pix_cnt;
			off_q <= line_off;
			sh_q  <= {8'h00, line_off, line_off};
			crc_q <= dvlps_pkg::CRC_INIT;
		end else if (busy_q) begin
			crc_q <= dvlps_pkg::crc_byte(crc_q, sh_q[23:16]);
			if (byte_q == 2'd2) begin
				sh_q <= {x_nxt[7:0], off_q, x_nxt[7:0] + off_q};
			end else begin
				sh_q <= {sh_q[15:0], 8'h00};
			end
		end
	end

	assign done = done_q;
	assign crc  = crc_q;

endmodule

FILE: hdl/dvlps_out_reg.sv
// Output register that builds the header ECC and holds a packet until it is taken.
`timescale 1ns / 1ps

module dvlps_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dvlps_pkg::pkt_t    pkt,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         dtype,
	output logic [1:0]         chan,
	output logic [13:0]        wcount,
	output logic [7:0]         ecc,
	output logic [15:0]        crc,
	output logic               has_crc,
	output logic               frame_start,
	output logic               last
);

	logic            valid_q;
	dvlps_pkg::pkt_t pkt_q;
	logic [7:0]      ecc_q;
	logic [7:0]      ecc_d;

	// The register takes a new request when empty or when its request leaves now.
	assign ready = !valid_q || !out_stall;

	// Header ECC: XOR of the three header bytes.
	assign ecc_d = {pkt.chan, pkt.dtype} ^ pkt.wcount[7:0]
		^ {2'b00, pkt.wcount[13:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			pkt_q <= pkt;
			ecc_q <= ecc_d;
		end
	end

	assign out_valid   = valid_q;
	assign dtype       = pkt_q.dtype;
	assign chan        = pkt_q.chan;
	assign wcount      = pkt_q.wcount;
	assign ecc         = ecc_q;
	assign crc         = pkt_q.crc;
	assign has_crc     = pkt_q.has_crc;
	assign frame_start = pkt_q.frame_start;
	assign last        = pkt_q.last;

endmodule

FILE: hdl/dsi_video_line_packet_sequencer.sv
// Top level of the DSI video line packet sequencer: registers, line counter, packet sequencing.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------------------
//   in       | sink      | in_valid / in_stall   | tick_valid
//   out      | source    | out_valid / out_stall | dtype chan wcount ecc crc has_crc
//            |           |                       | frame_start last
//   cfg      | sink      | cfg_we                | cfg_index cfg_data
//
// A tick request is taken in the idle state, decoded in the next cycle, and then its packets are
// issued one per cycle while the output register has room; the pixel packet also waits for the
// payload CRC. The byte-serial payload CRC of an active line runs alongside the sync headers.
// Reset returns the registers to their defaults and the line counter to zero.
// A stalled output holds the sequencer; the next tick is taken once the last packet is issued.
`timescale 1ns / 1ps

module dsi_video_line_packet_sequencer #(
	parameter int LINE_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                tick_valid,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [5:0]                          dtype,
	output logic [1:0]                          chan,
	output logic [13:0]                         wcount,
	output logic [7:0]                          ecc,
	output logic [15:0]                         crc,
	output logic                                has_crc,
	output logic                                frame_start,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [dvlps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dvlps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Width that holds a line number plus one as well as the frame height.
	localparam int AW = (LINE_BITS + 1 > 14) ? LINE_BITS + 1 : 14;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_VSYNC  = 6'b000100,
		ST_HSS    = 6'b001000,
		ST_PIX    = 6'b010000,
		ST_HSE    = 6'b100000
	} state_t;

	logic                 enable_q;
	logic [7:0]           vsync_q;
	logic [7:0]           vback_q;
	logic [11:0]          vactive_q;
	logic [7:0]           vfront_q;
	logic [11:0]          hactive_q;
	logic [1:0]           chan_q;
	logic [1:0]           fmt_q;

	state_t               state_q;
	logic [LINE_BITS-1:0] line_q;
	logic                 fs_q;
	logic                 vse_q;
	logic                 act_q;

	logic [13:0]          total;
	logic [LINE_BITS:0]   nxt;
	logic                 wrap;
	logic [8:0]           start_lines;
	logic [AW-1:0]        line_ext;
	logic [AW-1:0]        act_end;
	logic                 act_now;
	logic [7:0]           line_off;
	logic                 crc_start;
	logic                 crc_done;
	logic [15:0]          crc_val;
	logic                 push;
	logic                 out_ready;
	dvlps_pkg::pkt_t      pkt;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			vsync_q   <= 8'd5;
			vback_q   <= 8'd20;
			vactive_q <= 12'd720;
			vfront_q  <= 8'd5;
			hactive_q <= 12'd1280;
			chan_q    <= 2'd0;
			fmt_q     <= dvlps_pkg::FMT_RGB888;
		end else if (cfg_we) begin
			case (cfg_index)
				dvlps_pkg::CFG_ENABLE:  enable_q  <= cfg_data[0];
				dvlps_pkg::CFG_VSYNC:   vsync_q   <= cfg_data[7:0];
				dvlps_pkg::CFG_VBACK:   vback_q   <= cfg_data[7:0];
				dvlps_pkg::CFG_VACTIVE: vactive_q <= cfg_data[11:0];
				dvlps_pkg::CFG_VFRONT:  vfront_q  <= cfg_data[7:0];
				dvlps_pkg::CFG_HACTIVE: hactive_q <= cfg_data[11:0];
				dvlps_pkg::CFG_CHANNEL: chan_q    <= cfg_data[1:0];
				dvlps_pkg::CFG_FORMAT:  fmt_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Line advance: wrap at the frame height or when the counter overflows.
	assign total = 14'(vsync_q) + 14'(vback_q) + 14'(vactive_q) + 14'(vfront_q);
	assign nxt   = {1'b0, line_q} + {{LINE_BITS{1'b0}}, 1'b1};
	assign wrap  = nxt[LINE_BITS] || (AW'(nxt) >= AW'(total));

	// Line classification for the decode step.
	assign start_lines = 9'(vsync_q) + 9'(vback_q);
	assign line_ext    = AW'(line_q);
	assign act_end     = AW'(start_lines) + AW'(vactive_q);
	assign act_now     = (line_ext >= AW'(start_lines)) && (line_ext < act_end)
		&& (hactive_q != 12'd0);
	assign line_off    = line_q[7:0] - start_lines[7:0];
	assign crc_start   = (state_q == ST_DECODE) && act_now;

	assign in_stall = (state_q != ST_IDLE);

	// Packet request for the current state.
	always_comb begin
		push            = 1'b0;
		pkt.dtype       = dvlps_pkg::DT_HSS;
		pkt.chan        = chan_q;
		pkt.wcount      = 14'd0;
		pkt.crc         = 16'h0000;
		pkt.has_crc     = 1'b0;
		pkt.frame_start = fs_q;
		pkt.last        = 1'b0;
		case (state_q)
			ST_VSYNC: begin
				push      = out_ready;
				pkt.dtype = vse_q ? dvlps_pkg::DT_VSE : dvlps_pkg::DT_VSS;
			end
			ST_HSS: begin
				push = out_ready;
			end
			ST_PIX: begin
				push        = out_ready && crc_done;
				pkt.dtype   = dvlps_pkg::pix_type(fmt_q);
				pkt.wcount  = 14'({hactive_q, 1'b0}) + 14'(hactive_q);
				pkt.crc     = crc_val;
				pkt.has_crc = 1'b1;
			end
			ST_HSE: begin
				push      = out_ready;
				pkt.dtype = dvlps_pkg::DT_HSE;
				pkt.last  = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer: one tick walks through the packets of its line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_q  <= '0;
			fs_q    <= 1'b0;
			vse_q   <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && tick_valid && enable_q) begin
						line_q  <= wrap ? '0 : nxt[LINE_BITS-1:0];
						fs_q    <= wrap;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					vse_q   <= (line_q != '0);
					act_q   <= act_now;
					state_q <= ((line_q == '0) || (line_ext == AW'(vsync_q))) ? ST_VSYNC : ST_HSS;
				end
				ST_VSYNC: begin
					if (push) begin
						fs_q    <= 1'b0;
						state_q <= ST_HSS;
					end
				end
				ST_HSS: begin
					if (push) begin
						fs_q    <= 1'b0;
						state_q <= act_q ? ST_PIX : ST_HSE;
					end
				end
				ST_PIX: begin
					if (push) begin
						fs_q    <= 1'b0;
						state_q <= ST_HSE;
					end
				end
				ST_HSE: begin
					if (push) begin
						fs_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	dvlps_crc_ser u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (crc_start),
		.pix_cnt  (hactive_q),
		.line_off (line_off),
		.done     (crc_done),
		.crc      (crc_val)
	);

	dvlps_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pkt         (pkt),
		.ready       (out_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dtype       (dtype),
		.chan        (chan),
		.wcount      (wcount),
		.ecc         (ecc),
		.crc         (crc),
		.has_crc     (has_crc),
		.frame_start (frame_start),
		.last        (last)
	);

endmodule

FILE: tb/sv/dsi_video_line_packet_sequencer_tb.sv
// Self-checking testbench of the DSI video line packet sequencer.
`timescale 1ns / 1ps

module dsi_video_line_packet_sequencer_tb;

	localparam int LINE_BITS = 13;
	localparam int HOLD_CYCLES = 300;
	localparam logic [dvlps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

	// One expected packet of a line.
	typedef struct {
		logic [5:0]  dtype;
		logic [1:0]  chan;
		logic [13:0] wcount;
		logic [7:0]  ecc;
		logic [15:0] crc;
		logic        has_crc;
		logic        frame_start;
		logic        last;
	} packet_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic                             tick_valid;
	logic                             out_valid;
	logic                             out_stall;
	logic [5:0]                       dtype;
	logic [1:0]                       chan;
	logic [13:0]                      wcount;
	logic [7:0]                       ecc;
	logic [15:0]                      crc;
	logic                             has_crc;
	logic                             frame_start;
	logic                             last;
	logic                             cfg_we;
	logic [dvlps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dvlps_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the registers and the line counter, at their reset values.
	logic                 cur_enable = 1'b0;
	logic [7:0]           cur_vsync = 8'd5;
	logic [7:0]           cur_vback = 8'd20;
	logic [11:0]          cur_vactive = 12'd720;
	logic [7:0]           cur_vfront = 8'd5;
	logic [11:0]          cur_hactive = 12'd1280;
	logic [1:0]           cur_chan = 2'd0;
	logic [1:0]           cur_format = dvlps_pkg::FMT_RGB888;
	logic [LINE_BITS-1:0] cur_line = '0;

	packet_t line_packets_exp[$];
	int      mismatches = 0;
	bit      idle_gaps = 1'b1;
	bit      stall_gaps = 1'b1;
	bit      hold_request = 1'b0;

	dsi_video_line_packet_sequencer #(.LINE_BITS(LINE_BITS)) i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// CRC16 of a test-pattern line: three bytes per pixel, reflected, LSB first.
	function automatic logic [15:0] line_payload_crc(input int npix, input int off);
		logic [15:0] c;
		logic [7:0]  bytes [3];
		c = dvlps_pkg::CRC_INIT;
		for (int x = 0; x < npix; x++) begin
			bytes[0] = x[7:0];
			bytes[1] = off[7:0];
			bytes[2] = x[7:0] + off[7:0];
			for (int k = 0; k < 3; k++) begin
				c = c ^ {8'h00, bytes[k]};
				for (int i = 0; i < 8; i++) begin
					c = c[0] ? ((c >> 1) ^ dvlps_pkg::CRC_POLY) : (c >> 1);
				end
			end
		end
		return c;
	endfunction

	function automatic logic [5:0] pixel_data_type(input logic [1:0] fmt);
		case (fmt)
			dvlps_pkg::FMT_RGB565:  return dvlps_pkg::DT_RGB565;
			dvlps_pkg::FMT_RGB666P: return dvlps_pkg::DT_RGB666P;
			dvlps_pkg::FMT_RGB666L: return dvlps_pkg::DT_RGB666L;
			default:                return dvlps_pkg::DT_RGB888;
		endcase
	endfunction

	// Header of one packet; the ECC folds the three header bytes together.
	function automatic packet_t make_packet(input logic [5:0] dt, input logic [13:0] wc,
			input logic [15:0] c, input logic has);
		packet_t p;
		p.dtype       = dt;
		p.chan        = cur_chan;
		p.wcount      = wc;
		p.ecc         = {cur_chan, dt} ^ wc[7:0] ^ {2'b00, wc[13:8]};
		p.crc         = c;
		p.has_crc     = has;
		p.frame_start = 1'b0;
		p.last        = 1'b0;
		return p;
	endfunction

	// Advance the line counter for one tick and queue the packets of the new line.
	task automatic predict_line_packets(input logic tv);
		packet_t pk[$];
		int      total;
		int      start;
		int      nxt;
		logic    fs;
		if (!tv || !cur_enable) return;
		total = cur_vsync + cur_vback + cur_vactive + cur_vfront;
		nxt = cur_line + 1;
		fs = 1'b0;
		if (nxt >= total || nxt >= (1 << LINE_BITS)) begin
			nxt = 0;
			fs = 1'b1;
		end
		cur_line = nxt[LINE_BITS-1:0];
		start = cur_vsync + cur_vback;

		// Vertical sync start on line zero, sync end at the sync width.
		if (nxt == 0)
			pk.insert(pk.size(), make_packet(dvlps_pkg::DT_VSS, '0, '0, 1'b0));
		else if (nxt == cur_vsync)
			pk.insert(pk.size(), make_packet(dvlps_pkg::DT_VSE, '0, '0, 1'b0));
		pk.insert(pk.size(), make_packet(dvlps_pkg::DT_HSS, '0, '0, 1'b0));

		// Active lines carry the pixel packet unless the line is zero pixels wide.
		if (nxt >= start && nxt < start + cur_vactive && cur_hactive != 0)
			pk.insert(pk.size(), make_packet(pixel_data_type(cur_format),
				14'(3 * cur_hactive), line_payload_crc(cur_hactive, nxt - start), 1'b1));
		pk.insert(pk.size(), make_packet(dvlps_pkg::DT_HSE, '0, '0, 1'b0));

		pk[0].frame_start = fs;
		pk[pk.size() - 1].last = 1'b1;
		foreach (pk[i]) line_packets_exp.insert(line_packets_exp.size(), pk[i]);
	endtask

	// Register write; the enable stays up so writes can follow back to back.
	task automatic write_reg(input dvlps_pkg::cfg_reg_t idx,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			dvlps_pkg::CFG_ENABLE:  cur_enable = val[0];
			dvlps_pkg::CFG_VSYNC:   cur_vsync = val[7:0];
			dvlps_pkg::CFG_VBACK:   cur_vback = val[7:0];
			dvlps_pkg::CFG_VACTIVE: cur_vactive = val[11:0];
			dvlps_pkg::CFG_VFRONT:  cur_vfront = val[7:0];
			dvlps_pkg::CFG_HACTIVE: cur_hactive = val[11:0];
			dvlps_pkg::CFG_CHANNEL: cur_chan = val[1:0];
			dvlps_pkg::CFG_FORMAT:  cur_format = val[1:0];
			default: ;
		endcase
	endtask

	// Program every register, plus one write to an unmapped index that must be ignored.
	task automatic program_regs(input logic en, input logic [dvlps_pkg::CFG_DATA_W-1:0] vs,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] vb,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] va,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] vf,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] ha,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] ch,
			input logic [dvlps_pkg::CFG_DATA_W-1:0] fmt);
		write_reg(dvlps_pkg::CFG_VSYNC, vs);
		write_reg(dvlps_pkg::CFG_VBACK, vb);
		write_reg(dvlps_pkg::CFG_VACTIVE, va);
		write_reg(dvlps_pkg::CFG_VFRONT, vf);
		write_reg(dvlps_pkg::CFG_HACTIVE, ha);
		write_reg(dvlps_pkg::CFG_CHANNEL, ch);
		write_reg(dvlps_pkg::CFG_FORMAT, fmt);
		cfg_index <= CFG_UNUSED;
		cfg_data <= dvlps_pkg::CFG_DATA_W'($urandom);
		@(posedge clk);
		write_reg(dvlps_pkg::CFG_ENABLE, {{(dvlps_pkg::CFG_DATA_W-1){1'b0}}, en});
		cfg_we <= 1'b0;
	endtask

	// Offer one tick request, after a random gap if idle gaps are on, and predict once it is taken.
	task automatic send_tick(input logic tv);
		int gap;
		gap = idle_gaps ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick_valid <= tv;
		do @(posedge clk); while (in_stall);
		predict_line_packets(tv);
	endtask

	// Let every expected packet arrive, then give a stray packet time to show up.
	task automatic wait_lines_done();
		in_valid <= 1'b0;
		while (line_packets_exp.size() != 0) @(posedge clk);
		repeat (3 * cur_hactive + 40) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] expv,
			input logic [31:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, expv, actv);
			mismatches++;
		end
	endtask

	// Receiver: random stall before each packet when stall gaps are on, or one long hold when asked.
	initial begin : packet_receiver
		packet_t exp_pkt;
		int      n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = stall_gaps ? $urandom_range(0, 14) : 0;
			if (hold_request) begin
				n = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (line_packets_exp.size() == 0) begin
				$display("%0t: unexpected packet, expected none, got dtype 0x%0h",
					$time, dtype);
				mismatches++;
			end else begin
				exp_pkt = line_packets_exp.pop_front();
				check_field("dtype", exp_pkt.dtype, dtype);
				check_field("chan", exp_pkt.chan, chan);
				check_field("wcount", exp_pkt.wcount, wcount);
				check_field("ecc", exp_pkt.ecc, ecc);
				check_field("crc", exp_pkt.crc, crc);
				check_field("has_crc", exp_pkt.has_crc, has_crc);
				check_field("frame_start", exp_pkt.frame_start, frame_start);
				check_field("last", exp_pkt.last, last);
			end
		end
	end

	// After reset the display is off, so ticks must produce nothing.
	task automatic test_disabled();
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		wait_lines_done();
	endtask

	// A tiny frame walked through to its wrap: sync start and end, active, porches.
	task automatic test_short_frame();
		program_regs(1'b1, 2, 1, 3, 1, 4, 3, dvlps_pkg::FMT_RGB565);
		send_tick(1'b0);
		repeat (7) send_tick(1'b1);
		wait_lines_done();
	endtask

	// One active line per pixel format, each on a different channel.
	task automatic test_pixel_formats();
		logic [1:0] fmts [4] = '{dvlps_pkg::FMT_RGB565, dvlps_pkg::FMT_RGB666P,
			dvlps_pkg::FMT_RGB666L, dvlps_pkg::FMT_RGB888};
		foreach (fmts[i]) begin
			program_regs(1'b1, 1, 0, 4095, 0, 5 + i, i, fmts[i]);
			send_tick(1'b1);
			wait_lines_done();
		end
	endtask

	// Zero sync width gives sync start only; a zero-pixel line has no pixel packet.
	task automatic test_special_cases();
		program_regs(1'b1, 0, 0, 2, 0, 0, 2, dvlps_pkg::FMT_RGB888);
		repeat (3) send_tick(1'b1);
		wait_lines_done();
		program_regs(1'b1, 0, 0, 2, 0, 3, 2, dvlps_pkg::FMT_RGB666L);
		repeat (3) send_tick(1'b1);
		wait_lines_done();
	endtask

	// Widest line and largest timing values.
	task automatic test_extremes();
		program_regs(1'b1, 1, 0, 1, 0, 4095, 3, dvlps_pkg::FMT_RGB888);
		repeat (2) send_tick(1'b1);
		wait_lines_done();
		program_regs(1'b1, 255, 255, 4095, 255, 1, 0, dvlps_pkg::FMT_RGB666P);
		repeat (2) send_tick(1'b1);
		wait_lines_done();
	endtask

	// Random small frames with random traffic shaping per phase.
	task automatic test_random_lines();
		for (int p = 0; p < 7; p++) begin
			idle_gaps = $urandom_range(0, 2) != 0;
			stall_gaps = $urandom_range(0, 2) != 0;
			program_regs($urandom_range(0, 6) != 0,
				($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4),
				$urandom_range(0, 3), $urandom_range(1, 10), $urandom_range(0, 3),
				($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48),
				$urandom_range(0, 3), $urandom_range(0, 3));
			repeat (17) send_tick($urandom_range(0, 7) != 0);
			wait_lines_done();
		end
		idle_gaps = 1'b1;
		stall_gaps = 1'b1;
	endtask

	// Receiver holds off for a long stretch while ticks keep coming back to back.
	task automatic test_backpressure();
		program_regs(1'b1, 1, 1, 4, 1, 6, 1, dvlps_pkg::FMT_RGB888);
		idle_gaps = 1'b0;
		stall_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (12) send_tick(1'b1);
		wait_lines_done();
		idle_gaps = 1'b1;
		stall_gaps = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		tick_valid <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= dvlps_pkg::CFG_ENABLE;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled();
		test_short_frame();
		test_pixel_formats();
		test_special_cases();
		test_extremes();
		test_random_lines();
		test_backpressure();

		if (mismatches == 0 && line_packets_exp.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/dvlps_pkg.sv
hdl/dvlps_crc_ser.sv
hdl/dvlps_out_reg.sv
hdl/dsi_video_line_packet_sequencer.sv
tb/sv/dsi_video_line_packet_sequencer_tb.sv
